// ===== rtl/itfp_pkg.sv =====
// itfp_pkg: shared types and constants of the integer text field parser
// no dependencies; imported by every rtl module of the block

package itfp_pkg;

	// base_mode codes
	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	// size_mode codes, anything else is 64-bit
	localparam logic [1:0] SIZE_32 = 2'd0;
	localparam logic [1:0] SIZE_16 = 2'd1;
	localparam logic [1:0] SIZE_64 = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_BASE_MODE = 2'd0;
	localparam logic [1:0] REG_MAX_WIDTH = 2'd1;
	localparam logic [1:0] REG_SIZE_MODE = 2'd2;

	// parser phase codes
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_DIGITS  = 3'd1;
	localparam logic [2:0] PH_HEXZERO = 3'd2;

	// width_left with bit 8 set means no limit
	localparam logic [8:0] WL_UNLIMITED = 9'h100;

	localparam int ACC_W = 64;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
		logic       text_end;
	} item_t;

	typedef struct packed {
		logic [1:0] base_mode;
		logic [7:0] max_width;
		logic [1:0] size_mode;
	} cfg_t;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic             negative;
		logic [8:0]       width_left;
		logic [2:0]       phase;
		logic             digit_seen;
		logic [7:0]       char_count;
	} state_t;

endpackage

// ===== rtl/itfp_if.sv =====
// itfp_if: handshake channel interfaces of the integer text field parser
// depends on nothing; used by the top level and its users

interface itfp_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       first;
	logic       text_end;

	modport source (output valid, ch, first, text_end, input ready);
	modport sink (input valid, ch, first, text_end, output ready);
endinterface

interface itfp_result_if;
	logic        valid;
	logic        ready;
	logic        consumed;
	logic        field_done;
	logic        parse_ok;
	logic [63:0] value_bits;
	logic [7:0]  chars_used;

	modport source (output valid, consumed, field_done, parse_ok, value_bits, chars_used,
		input ready);
	modport sink (input valid, consumed, field_done, parse_ok, value_bits, chars_used,
		output ready);
endinterface

interface itfp_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/integer_text_field_parser.sv =====
// integer_text_field_parser: scanf-style integer field parser, top level
// depends on itfp_pkg, itfp_if, itfp_cfg, itfp_step, itfp_fmt
//
// Usage
//   item: one text character per beat (ch, first, text_end). first opens a
//     new field and clears the parser; text_end closes it, ch ignored.
//   result: one beat per character: consumed, field_done, parse_ok, the
//     sized sign-extended value_bits and chars_used so far.
//   cfg: register writes (0 base_mode, 1 max_width, 2 size_mode), always
//     ready; the user must write only while the parser holds no beat, the block does not enforce it.
// Pipeline and throughput
//   a result passes through the input register, then the state update,
//   then the result register. One character per cycle while result.ready
//   stays high; the 64-bit shift-add of the accumulator sets the cycle.
// Reset
//   arst_n clears configuration, parser state and all valid flags; the
//   parser starts with the field finished.
// Stalls
//   when result.ready is low the result register holds; the input and state
//   stages keep filling until all three are occupied, then item.ready drops.

module integer_text_field_parser
	import itfp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	itfp_item_if.sink     item,
	itfp_result_if.source result,
	itfp_cfg_if.sink      cfg
);

	cfg_t        cfg_live;
	state_t      state;
	logic        took;
	logic        fmt_done;
	logic        fmt_ok;
	logic [63:0] fmt_value;

	logic        adv1;
	logic        adv2;
	logic        adv3;
	logic        valid_s1;
	logic        valid_s2;
	logic        valid_s3;
	item_t       item_s1;
	logic        took_s2;
	logic        consumed_s3;
	logic        done_s3;
	logic        ok_s3;
	logic [63:0] value_s3;
	logic [7:0]  count_s3;

	itfp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.wr_ready (cfg.ready),
		.cfg      (cfg_live)
	);

	// stage enables, each stage moves when empty or drained downstream
	assign adv3       = !valid_s3 || result.ready;
	assign adv2       = !valid_s2 || adv3;
	assign adv1       = !valid_s1 || adv2;
	assign item.ready = adv1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && item.valid) begin
			item_s1 <= '{ch: item.ch, first: item.first, text_end: item.text_end};
		end
	end

	itfp_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv2 && valid_s1),
		.itm    (item_s1),
		.cfg    (cfg_live),
		.took   (took),
		.state  (state)
	);

	// state stage bookkeeping, the state registers hold the rest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			took_s2 <= took;
		end
	end

	itfp_fmt u_fmt (
		.state      (state),
		.cfg        (cfg_live),
		.field_done (fmt_done),
		.parse_ok   (fmt_ok),
		.value_bits (fmt_value)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			consumed_s3 <= took_s2;
			done_s3     <= fmt_done;
			ok_s3       <= fmt_ok;
			value_s3    <= fmt_value;
			count_s3    <= state.char_count;
		end
	end

	assign result.valid      = valid_s3;
	assign result.consumed   = consumed_s3;
	assign result.field_done = done_s3;
	assign result.parse_ok   = ok_s3;
	assign result.value_bits = value_s3;
	assign result.chars_used = count_s3;

	// an exhausted width limit always closes the field
	a_width_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(!state.width_left[8] && (state.width_left == 9'd0)) |-> (state.phase == PH_IDLE))
		else $error("width limit exhausted with field still open");

	// the character count moves only when a beat enters the state stage
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(state.char_count) |-> $past(valid_s1 && adv2))
		else $error("character count changed without a beat");

	// a consumed character is always counted
	a_consumed_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.consumed) |-> (result.chars_used != 8'd0))
		else $error("consumed character with zero count");

	// parse_ok only on a finished field
	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.parse_ok) |-> result.field_done)
		else $error("parse_ok without field_done");

endmodule

// ===== rtl/itfp_cfg.sv =====
// itfp_cfg: configuration register file (base, width limit, result size)
// depends on itfp_pkg

module itfp_cfg
	import itfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data,
	output logic       wr_ready,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	// writes are always accepted and registered directly
	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	// register decode, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_valid) begin
			unique case (wr_index)
				REG_BASE_MODE: cfg_q.base_mode <= wr_data[1:0];
				REG_MAX_WIDTH: cfg_q.max_width <= wr_data;
				REG_SIZE_MODE: cfg_q.size_mode <= wr_data[1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/itfp_step.sv =====
// itfp_step: parser state registers and the one-character update logic
// depends on itfp_pkg

module itfp_step
	import itfp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  item_t  itm,
	input  cfg_t   cfg,
	output logic   took,
	output state_t state
);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;

	state_t     state_q;
	state_t     state_d;
	logic       hex;
	logic       limited;
	logic       width_used;
	logic       is_dec_digit;
	logic       is_hex_letter;
	logic       is_hex_digit;
	logic [3:0] hex_digit;
	logic [7:0] top_char;
	logic       prefix_ok;

	assign state = state_q;

	// character classes
	assign hex           = (cfg.base_mode == BASE_HEX);
	assign top_char      = (cfg.base_mode == BASE_OCT) ? CH_SEVEN : CH_NINE;
	assign is_dec_digit  = (itm.ch >= CH_ZERO) && (itm.ch <= CH_NINE);
	assign is_hex_letter = ((itm.ch >= CH_UP_A) && (itm.ch <= CH_UP_F)) ||
		((itm.ch >= CH_LOW_A) && (itm.ch <= CH_LOW_F));
	assign is_hex_digit  = is_dec_digit || is_hex_letter;
	assign hex_digit     = is_hex_letter ? itm.ch[3:0] + 4'd9 : itm.ch[3:0];

	// next state for one character
	always_comb begin
		state_d    = state_q;
		took       = 1'b0;
		width_used = 1'b0;
		limited    = 1'b0;
		prefix_ok  = 1'b0;
		if (itm.first) begin
			state_d.acc        = '0;
			state_d.negative   = 1'b0;
			state_d.digit_seen = 1'b0;
			state_d.char_count = '0;
			state_d.width_left = (cfg.max_width != 8'd0) ? {1'b0, cfg.max_width} : WL_UNLIMITED;
			state_d.phase      = PH_DIGITS;
		end
		if (itm.text_end) begin
			state_d.phase = PH_IDLE;
		end else if (state_d.phase != PH_IDLE) begin
			limited   = !state_d.width_left[8];
			prefix_ok = !limited || (state_d.width_left >= 9'd2);
			if (hex) begin
				if ((state_d.phase == PH_HEXZERO) && prefix_ok &&
					((itm.ch == CH_LOW_X) || (itm.ch == CH_UP_X))) begin
					state_d.acc        = '0;
					state_d.digit_seen = 1'b0;
					state_d.phase      = PH_DIGITS;
					took               = 1'b1;
					width_used         = 1'b1;
				end else if (is_hex_digit) begin
					state_d.acc        = {state_d.acc[ACC_W-5:0], hex_digit};
					state_d.digit_seen = 1'b1;
					state_d.phase      = (itm.first && (itm.ch == CH_ZERO)) ? PH_HEXZERO : PH_DIGITS;
					took               = 1'b1;
					width_used         = 1'b1;
				end else begin
					state_d.phase = PH_IDLE;
				end
			end else begin
				if (itm.first && ((itm.ch == CH_PLUS) || (itm.ch == CH_MINUS))) begin
					state_d.negative = (itm.ch == CH_MINUS);
					took             = 1'b1;
				end else if ((itm.ch >= CH_ZERO) && (itm.ch <= top_char)) begin
					// times eight or ten as a shift-add
					if (cfg.base_mode == BASE_OCT) begin
						state_d.acc = {state_d.acc[ACC_W-4:0], 3'd0} |
							{{(ACC_W-4){1'b0}}, itm.ch[3:0]};
					end else begin
						state_d.acc = {state_d.acc[ACC_W-4:0], 3'd0} +
							{state_d.acc[ACC_W-2:0], 1'b0} +
							{{(ACC_W-4){1'b0}}, itm.ch[3:0]};
					end
					state_d.digit_seen = 1'b1;
					took               = 1'b1;
					width_used         = 1'b1;
				end else begin
					state_d.phase = PH_IDLE;
				end
			end
			// count and width bookkeeping
			if (took) begin
				if (state_d.char_count != 8'hFF) begin
					state_d.char_count = state_d.char_count + 8'd1;
				end
				if (width_used && limited) begin
					if (state_d.width_left != 9'd0) begin
						state_d.width_left = state_d.width_left - 9'd1;
					end
					if (state_d.width_left == 9'd0) begin
						state_d.phase = PH_IDLE;
					end
				end
			end
		end
	end

	// state registers, advance once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
		end else if (en) begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/itfp_fmt.sv =====
// itfp_fmt: result shaping: sign, size truncation, sign extension, status
// depends on itfp_pkg

module itfp_fmt
	import itfp_pkg::*;
(
	input  state_t      state,
	input  cfg_t        cfg,
	output logic        field_done,
	output logic        parse_ok,
	output logic [63:0] value_bits
);

	logic [ACC_W-1:0] signed_val;

	// status
	assign field_done = (state.phase == PH_IDLE);
	assign parse_ok   = field_done && ((cfg.base_mode != BASE_HEX) || state.digit_seen);

	// two's complement negate of the magnitude
	assign signed_val = state.negative ? (~state.acc + 64'd1) : state.acc;

	// truncate and sign-extend
	always_comb begin
		case (cfg.size_mode)
			SIZE_32: value_bits = {{32{signed_val[31]}}, signed_val[31:0]};
			SIZE_16: value_bits = {{48{signed_val[15]}}, signed_val[15:0]};
			default: value_bits = signed_val;
		endcase
	end

endmodule

// ===== tb/integer_text_field_parser_tb.sv =====
`timescale 1ns / 100ps
// integer_text_field_parser_tb: self-checking bench for the integer text field parser
// depends on itfp_pkg, itfp_if and integer_text_field_parser; per-character field
// predictor in a small scoreboard class, random gaps and stalls on both channels

module integer_text_field_parser_tb;
	import itfp_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int IDLE_LIMIT    = 2000;
	localparam int PHASES        = 6;
	localparam int PHASE_CHARS   = 50;
	localparam int LONG_DIGITS   = 258;

	// no register answers to this index
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_SEVEN   = "7";
	localparam logic [7:0] CH_NINE    = "9";
	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_UPPER_F = "F";
	localparam logic [7:0] CH_LOWER_A = "a";
	localparam logic [7:0] CH_LOWER_F = "f";
	localparam logic [7:0] CH_UPPER_X = "X";
	localparam logic [7:0] CH_LOWER_X = "x";
	localparam logic [7:0] CH_PLUS    = "+";
	localparam logic [7:0] CH_MINUS   = "-";
	localparam logic [7:0] CH_SPACE   = " ";

	typedef struct packed {
		logic        consumed;
		logic        field_done;
		logic        parse_ok;
		logic [63:0] value_bits;
		logic [7:0]  chars_used;
	} parse_res_t;

	// field parser prediction and result checking
	class field_scoreboard;
		cfg_t       regs;
		state_t     st;
		parse_res_t results_due[$];
		int         mismatches;

		function new();
			regs = '0;
			st = '0;
			st.phase = PH_IDLE;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] data);
			case (idx)
				REG_BASE_MODE: regs.base_mode = data[1:0];
				REG_MAX_WIDTH: regs.max_width = data;
				REG_SIZE_MODE: regs.size_mode = data[1:0];
				default: ;
			endcase
		endfunction

		function int hex_digit(logic [7:0] c);
			if (c >= CH_ZERO && c <= CH_NINE)
				return c - CH_ZERO;
			if (c >= CH_UPPER_A && c <= CH_UPPER_F)
				return c - CH_UPPER_A + 10;
			if (c >= CH_LOWER_A && c <= CH_LOWER_F)
				return c - CH_LOWER_A + 10;
			return -1;
		endfunction

		// advance the field state by one character and queue the result it gives
		function void note_char(item_t it);
			logic       hex;
			logic       took;
			logic       width_used;
			logic       limited;
			logic [7:0] top;
			logic [63:0] radix;
			logic [63:0] mag;
			int         d;
			parse_res_t want;
			hex = (regs.base_mode == BASE_HEX);
			took = 1'b0;
			width_used = 1'b0;
			if (it.first) begin
				st.acc = '0;
				st.negative = 1'b0;
				st.digit_seen = 1'b0;
				st.char_count = '0;
				st.width_left = (regs.max_width != 0) ? {1'b0, regs.max_width} : WL_UNLIMITED;
				st.phase = PH_DIGITS;
			end
			if (it.text_end) begin
				st.phase = PH_IDLE;
			end else if (st.phase != PH_IDLE) begin
				limited = !st.width_left[8];
				if (hex) begin
					d = hex_digit(it.ch);
					// prefix needs room for itself plus a digit
					if (st.phase == PH_HEXZERO && (it.ch == CH_LOWER_X || it.ch == CH_UPPER_X)
							&& (!limited || st.width_left >= 9'd2)) begin
						st.acc = '0;
						st.digit_seen = 1'b0;
						st.phase = PH_DIGITS;
						took = 1'b1;
						width_used = 1'b1;
					end else if (d >= 0) begin
						st.acc = (st.acc << 4) + 64'(d);
						st.digit_seen = 1'b1;
						st.phase = (it.first && it.ch == CH_ZERO) ? PH_HEXZERO : PH_DIGITS;
						took = 1'b1;
						width_used = 1'b1;
					end else begin
						st.phase = PH_IDLE;
					end
				end else begin
					top = (regs.base_mode == BASE_OCT) ? CH_SEVEN : CH_NINE;
					radix = (regs.base_mode == BASE_OCT) ? 64'd8 : 64'd10;
					if (it.first && (it.ch == CH_PLUS || it.ch == CH_MINUS)) begin
						st.negative = (it.ch == CH_MINUS);
						took = 1'b1;
					end else if (it.ch >= CH_ZERO && it.ch <= top) begin
						st.acc = st.acc * radix + {56'd0, it.ch - CH_ZERO};
						st.digit_seen = 1'b1;
						took = 1'b1;
						width_used = 1'b1;
					end else begin
						st.phase = PH_IDLE;
					end
				end
				if (took) begin
					if (st.char_count != 8'hff)
						st.char_count++;
					if (width_used && limited) begin
						if (st.width_left != 0)
							st.width_left--;
						if (st.width_left == 0)
							st.phase = PH_IDLE;
					end
				end
			end

			// size and sign-extend the magnitude
			mag = st.negative ? (64'd0 - st.acc) : st.acc;
			case (regs.size_mode)
				SIZE_32: want.value_bits = {{32{mag[31]}}, mag[31:0]};
				SIZE_16: want.value_bits = {{48{mag[15]}}, mag[15:0]};
				default: want.value_bits = mag;
			endcase
			want.consumed = took;
			want.field_done = (st.phase == PH_IDLE);
			want.parse_ok = want.field_done && (!hex || st.digit_seen);
			want.chars_used = st.char_count;
			results_due.push_back(want);
		endfunction

		function void report(string what, parse_res_t want, parse_res_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch (%s): expected consumed=%0b done=%0b ok=%0b value=%h used=%0d,",
					what, want.consumed, want.field_done, want.parse_ok, want.value_bits,
					want.chars_used,
					" got consumed=%0b done=%0b ok=%0b value=%h used=%0d",
					got.consumed, got.field_done, got.parse_ok, got.value_bits, got.chars_used);
		endfunction

		function void check_result(parse_res_t got);
			parse_res_t want;
			string bad;
			if (results_due.size() == 0) begin
				report("no beat pending", '0, got);
				return;
			end
			want = results_due.pop_front();
			bad = "";
			if (got.consumed !== want.consumed)
				bad = {bad, " consumed"};
			if (got.field_done !== want.field_done)
				bad = {bad, " field_done"};
			if (got.parse_ok !== want.parse_ok)
				bad = {bad, " parse_ok"};
			if (got.value_bits !== want.value_bits)
				bad = {bad, " value_bits"};
			if (got.chars_used !== want.chars_used)
				bad = {bad, " chars_used"};
			if (bad != "")
				report(bad, want, got);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm;
	int   chars_sent;

	field_scoreboard sb;

	itfp_item_if   item_ch();
	itfp_result_if result_ch();
	itfp_cfg_if    cfg_ch();

	integer_text_field_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly short gaps, a few long ones, none in a calm phase
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t char_item(logic [7:0] c, logic f, logic e);
		item_t it;
		it.ch = c;
		it.first = f;
		it.text_end = e;
		return it;
	endfunction

	function automatic logic [7:0] digit_char(logic [1:0] b);
		int v;
		if (b == BASE_HEX) begin
			v = $urandom_range(0, 15);
			if (v < 10)
				return CH_ZERO + 8'(v);
			return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 10);
		end
		// octal now and then gets an 8 or 9, which ends the field
		if (b == BASE_OCT)
			return CH_ZERO + 8'((($urandom_range(0, 11) == 0) ? $urandom_range(8, 9)
				: $urandom_range(0, 7)));
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// one character beat on the item channel
	task automatic push_char(item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.ch <= it.ch;
		item_ch.first <= it.first;
		item_ch.text_end <= it.text_end;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_char(it);
		chars_sent++;
	endtask

	// stop sending and wait for every pending result
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (sb.results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers back to back, sometimes also the unused index
	task automatic configure(logic [1:0] b, logic [7:0] w, logic [1:0] s);
		logic [1:0] idx [4];
		logic [7:0] val [4];
		int n;
		idx = '{REG_BASE_MODE, REG_MAX_WIDTH, REG_SIZE_MODE, REG_UNUSED};
		val = '{{6'd0, b}, w, {6'd0, s}, 8'($urandom_range(0, 255))};
		n = ($urandom_range(0, 3) == 0) ? 4 : 3;
		for (int k = 0; k < n; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[k];
			cfg_ch.data <= val[k];
			do @(posedge clk); while (!cfg_ch.ready);
			sb.write_reg(idx[k], val[k]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// one field: mostly well formed with random content, some noise
	task automatic random_field(logic [1:0] b);
		item_t q[$];
		item_t it;
		int ndig;
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			it.ch = 8'($urandom_range(0, 255));
			it.first = ($urandom_range(0, 3) == 0);
			it.text_end = ($urandom_range(0, 5) == 0);
			q.push_back(it);
		end else begin
			if (b == BASE_HEX) begin
				if ($urandom_range(0, 2) == 0) begin
					q.push_back(char_item(CH_ZERO, 1'b0, 1'b0));
					q.push_back(char_item($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X,
						1'b0, 1'b0));
				end
			end else begin
				r = $urandom_range(0, 2);
				if (r == 1)
					q.push_back(char_item(CH_PLUS, 1'b0, 1'b0));
				else if (r == 2)
					q.push_back(char_item(CH_MINUS, 1'b0, 1'b0));
			end
			ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
			repeat (ndig) q.push_back(char_item(digit_char(b), 1'b0, 1'b0));
			// terminator: end of text, any byte, a space, or just the next field
			r = $urandom_range(0, 3);
			if (r == 0)
				q.push_back(char_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
			else if (r == 1)
				q.push_back(char_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
			else if (r == 2)
				q.push_back(char_item(CH_SPACE, 1'b0, 1'b0));
			if (q.size() == 0)
				q.push_back(char_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
			q[0].first = 1'b1;
			// characters after the field is done
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2))
					q.push_back(char_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
		end
		foreach (q[k])
			push_char(q[k]);
	endtask

	// result sink with random stalls
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// check every result beat
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result('{result_ch.consumed, result_ch.field_done, result_ch.parse_ok,
				result_ch.value_bits, result_ch.chars_used});
	end

	// watchdog on cycles with no beat on any channel
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [1:0] b;
		logic [1:0] s;
		logic [7:0] w;
		int r;
		int mark;
		sb = new();
		calm = 1'b0;
		chars_sent = 0;
		item_ch.valid <= 1'b0;
		item_ch.ch <= '0;
		item_ch.first <= 1'b0;
		item_ch.text_end <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decimal at reset settings: char before any field, signed value, sign only, empty
		push_char(char_item(CH_UPPER_A, 1'b0, 1'b0));
		push_char(char_item(CH_MINUS, 1'b1, 1'b0));
		push_char(char_item(CH_ZERO + 8'd1, 1'b0, 1'b0));
		push_char(char_item(CH_ZERO + 8'd2, 1'b0, 1'b0));
		push_char(char_item(8'hff, 1'b0, 1'b1));
		push_char(char_item(CH_PLUS, 1'b1, 1'b0));
		push_char(char_item(8'h00, 1'b0, 1'b0));
		push_char(char_item(8'h00, 1'b1, 1'b1));
		settle();

		// hex: prefix only fails, prefixed value, no digit at all
		configure(BASE_HEX, 8'd0, SIZE_64);
		push_char(char_item(CH_ZERO, 1'b1, 1'b0));
		push_char(char_item(CH_LOWER_X, 1'b0, 1'b0));
		push_char(char_item(CH_LOWER_A + 8'd6, 1'b0, 1'b0));
		push_char(char_item(CH_ZERO, 1'b1, 1'b0));
		push_char(char_item(CH_UPPER_X, 1'b0, 1'b0));
		push_char(char_item(CH_LOWER_A, 1'b0, 1'b0));
		push_char(char_item(CH_UPPER_F, 1'b0, 1'b0));
		push_char(char_item(CH_SPACE, 1'b0, 1'b1));
		push_char(char_item(CH_LOWER_A + 8'd6, 1'b1, 1'b0));
		settle();

		// octal, width 2: width runs out, char after done, 8 stops the field
		configure(BASE_OCT, 8'd2, SIZE_16);
		push_char(char_item(CH_MINUS, 1'b1, 1'b0));
		push_char(char_item(CH_SEVEN, 1'b0, 1'b0));
		push_char(char_item(CH_SEVEN, 1'b0, 1'b0));
		push_char(char_item(CH_ZERO + 8'd8, 1'b0, 1'b0));
		push_char(char_item(CH_ZERO + 8'd8, 1'b1, 1'b0));
		settle();

		// widest limit with a long field, char count saturates
		configure(BASE_DEC, 8'd255, SIZE_64);
		push_char(char_item(CH_PLUS, 1'b1, 1'b0));
		repeat (LONG_DIGITS) push_char(char_item(digit_char(BASE_DEC), 1'b0, 1'b0));
		push_char(char_item(CH_SPACE, 1'b0, 1'b0));
		repeat (5) random_field(BASE_DEC);
		settle();

		// random phases, the first with the unused base and size codes
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				b = 2'd3;
				w = 8'd1;
				s = 2'd3;
			end else begin
				b = 2'($urandom_range(0, 3));
				r = $urandom_range(0, 99);
				w = (r < 35) ? 8'd0 : (r < 85) ? 8'($urandom_range(1, 8))
					: 8'($urandom_range(9, 255));
				s = 2'($urandom_range(0, 3));
			end
			calm = ($urandom_range(0, 3) == 0);
			configure(b, w, s);
			mark = chars_sent;
			while (chars_sent - mark < PHASE_CHARS)
				random_field(b);
			settle();
		end

		if (sb.mismatches == 0 && sb.results_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
